// ----- rtl/core/ccp_pkg.sv -----
// ---------------------------------------------------------------------------
// ccp_pkg
// Shared types and constants for the command parser.
// ---------------------------------------------------------------------------
package ccp_pkg;

    localparam int LINE_CAPACITY = 63;
    localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
    localparam int STORE_DEPTH   = 13;
    localparam int FREQ_DIGITS   = 11;
    localparam logic [31:0] FREQ_RESET = 32'd7074000;
    localparam logic [7:0]  MODE_RESET = 8'd3;
    localparam logic [7:0]  CHAR_SEMI  = 8'h3B;

    typedef struct packed {
        logic [1:0] channel;
        logic [7:0] rx_byte;
    } ccp_in_t;

    typedef struct packed {
        logic [1:0]  reply_channel;
        logic        kind;
        logic [7:0]  tx_byte;
        logic [31:0] tuned_freq;
        logic        last;
    } ccp_out_t;

    // Reply templates
    typedef enum logic [2:0] {
        RPL_FA, RPL_IF, RPL_ID, RPL_PS, RPL_AI, RPL_MD
    } ccp_reply_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_CONV, ST_PARSE, ST_SEND, ST_TUNE
    } ccp_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       store_byte;
        logic       clear_count;
        logic       conv_start;
        logic       conv_step;
        logic       parse_step;
        logic       parse_start;
        logic       set_freq;
        logic       tune_show;
        logic       set_mode;
        logic       set_tx;
        logic       clr_tx;
        logic       latch_ch;
        logic       idx_clear;
        logic       idx_inc;
        ccp_reply_t reply;
    } ccp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       is_semi;
        logic [CNT_W-1:0] len;
        logic       is_fa, is_if, is_id, is_ps, is_ai, is_md, is_rx, is_tx;
        logic       conv_done;
        logic       parse_done;
        logic       reply_end;
    } ccp_stat_t;

endpackage

// ----- rtl/core/ccp_datapath.sv -----
// ---------------------------------------------------------------------------
// ccp_datapath
// Line store, state registers, decimal conversion and reply byte generator.
// ---------------------------------------------------------------------------
module ccp_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ccp_pkg::ccp_in_t  in_item,
    input  ccp_pkg::ccp_cmd_t cmd,
    output ccp_pkg::ccp_stat_t stat,
    output ccp_pkg::ccp_out_t out_item
);
    logic [7:0]  store_reg [ccp_pkg::STORE_DEPTH];
    logic [ccp_pkg::CNT_W-1:0] count_reg;
    logic [31:0] freq_reg;
    logic [7:0]  mode_reg;
    logic        tx_reg;
    logic [1:0]  ch_reg;
    // decimal digits of frequency, most significant first
    logic [3:0]  dig_reg [ccp_pkg::FREQ_DIGITS];
    logic [31:0] conv_reg;
    logic [3:0]  step_reg;
    logic [32:0] acc_reg;
    logic        pstop_reg;
    logic [3:0]  pidx_reg;
    logic [5:0]  idx_reg;

    logic        printable;
    logic [7:0]  b;
    logic [31:0] q;
    logic [3:0]  r;
    logic [7:0]  pd;
    logic [36:0] acc_next;
    logic [7:0]  mh, mt, mo;
    logic [7:0]  mrem;
    logic [15:0] mprod;
    logic [3:0]  mhund, mtens;
    logic [7:0]  ch0, ch1;
    logic [5:0]  rlen;
    logic [7:0]  rbyte;

    assign b = in_item.rx_byte;
    assign printable = (b >= 8'h20) && (b <= 8'h7E);

    // input capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clear_count)
        begin
            count_reg <= '0;
        end
        else if (cmd.store_byte && printable
                 && count_reg < ccp_pkg::CNT_W'(ccp_pkg::LINE_CAPACITY))
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte && printable
            && count_reg < ccp_pkg::CNT_W'(ccp_pkg::STORE_DEPTH))
        begin
            store_reg[count_reg[3:0]] <= b;
        end
        if (cmd.latch_ch)
        begin
            ch_reg <= in_item.channel;
        end
    end

    // persistent radio state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= ccp_pkg::FREQ_RESET;
            mode_reg <= ccp_pkg::MODE_RESET;
            tx_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.set_freq) freq_reg <= acc_reg[31:0];
            if (cmd.set_mode) mode_reg <= store_reg[2] - 8'h30;
            if (cmd.set_tx)   tx_reg   <= 1'b1;
            if (cmd.clr_tx)   tx_reg   <= 1'b0;
        end
    end

    // binary to decimal, one digit a cycle (divide by ten via reciprocal)
    always_comb
    begin
        q = 32'((64'(conv_reg) * 64'hCCCCCCCD) >> 35);
        r = 4'(conv_reg - 32'(q * 32'd10));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.conv_start)
        begin
            conv_reg <= freq_reg;
            step_reg <= 4'd0;
        end
        else if (cmd.conv_step)
        begin
            conv_reg <= q;
            step_reg <= step_reg + 1'b1;
            dig_reg[4'(ccp_pkg::FREQ_DIGITS - 1) - step_reg] <= r;
        end
    end

    // decimal to binary, one digit a cycle with saturation
    assign pd = store_reg[pidx_reg];
    always_comb
    begin
        acc_next = 37'(acc_reg) * 37'd10 + 37'(pd - 8'h30);
        if (acc_next > 37'hFFFFFFFF) acc_next = 37'hFFFFFFFF;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.parse_start)
        begin
            acc_reg   <= '0;
            pidx_reg  <= 4'd2;
            pstop_reg <= 1'b0;
        end
        else if (cmd.parse_step)
        begin
            if (!pstop_reg && pd >= 8'h30 && pd <= 8'h39)
            begin
                acc_reg <= acc_next[32:0];
            end
            else
            begin
                pstop_reg <= 1'b1;
            end
            pidx_reg <= pidx_reg + 1'b1;
        end
    end

    // reply byte index
    always_ff @(posedge clk)
    begin
        if (cmd.idx_clear)    idx_reg <= '0;
        else if (cmd.idx_inc) idx_reg <= idx_reg + 1'b1;
    end

    // mode digits (value below 256): hundreds by compare, tens by reciprocal
    always_comb
    begin
        if (mode_reg >= 8'd200)
        begin
            mhund = 4'd2;
            mrem  = mode_reg - 8'd200;
        end
        else if (mode_reg >= 8'd100)
        begin
            mhund = 4'd1;
            mrem  = mode_reg - 8'd100;
        end
        else
        begin
            mhund = 4'd0;
            mrem  = mode_reg;
        end
        // x * 205 >> 11 is x / 10 for x below 100
        mprod = 16'(mrem) * 16'd205;
        mtens = 4'(mprod >> 11);
        mh = 8'h30 + 8'(mhund);
        mt = 8'h30 + 8'(mtens);
        mo = 8'h30 + (mrem - 8'(mtens) * 8'd10);
    end

    // reply byte selection
    always_comb
    begin
        rbyte = 8'h3B;
        rlen  = 6'd1;
        case (cmd.reply)
            ccp_pkg::RPL_FA:
            begin
                rlen = 6'd14;
                if (idx_reg == 6'd0) rbyte = "F";
                else if (idx_reg == 6'd1) rbyte = "A";
                else if (idx_reg < 6'd13) rbyte = 8'h30 + 8'(dig_reg[4'(idx_reg - 6'd2)]);
            end
            ccp_pkg::RPL_IF:
            begin
                rlen = 6'd38;
                if (idx_reg == 6'd0) rbyte = "I";
                else if (idx_reg == 6'd1) rbyte = "F";
                else if (idx_reg < 6'd13) rbyte = 8'h30 + 8'(dig_reg[4'(idx_reg - 6'd2)]);
                else if (idx_reg < 6'd18) rbyte = " ";
                else if (idx_reg == 6'd18) rbyte = "+";
                else if (idx_reg < 6'd28) rbyte = "0";
                else if (idx_reg == 6'd28) rbyte = tx_reg ? "1" : "0";
                else if (idx_reg == 6'd29) rbyte = mo;
                else if (idx_reg < 6'd37) rbyte = "0";
            end
            ccp_pkg::RPL_ID:
            begin
                rlen = 6'd6;
                case (idx_reg)
                    6'd0: rbyte = "I";
                    6'd1: rbyte = "D";
                    6'd2: rbyte = "0";
                    6'd3: rbyte = "2";
                    6'd4: rbyte = "0";
                    default: rbyte = 8'h3B;
                endcase
            end
            ccp_pkg::RPL_PS:
            begin
                rlen = 6'd4;
                case (idx_reg)
                    6'd0: rbyte = "P";
                    6'd1: rbyte = "S";
                    6'd2: rbyte = "1";
                    default: rbyte = 8'h3B;
                endcase
            end
            ccp_pkg::RPL_AI:
            begin
                rlen = 6'd4;
                case (idx_reg)
                    6'd0: rbyte = "A";
                    6'd1: rbyte = "I";
                    6'd2: rbyte = "0";
                    default: rbyte = 8'h3B;
                endcase
            end
            ccp_pkg::RPL_MD:
            begin
                // variable width: no leading zeros
                if (mode_reg >= 8'd100)
                begin
                    rlen = 6'd6;
                    case (idx_reg)
                        6'd0: rbyte = "M";
                        6'd1: rbyte = "D";
                        6'd2: rbyte = mh;
                        6'd3: rbyte = mt;
                        6'd4: rbyte = mo;
                        default: rbyte = 8'h3B;
                    endcase
                end
                else if (mode_reg >= 8'd10)
                begin
                    rlen = 6'd5;
                    case (idx_reg)
                        6'd0: rbyte = "M";
                        6'd1: rbyte = "D";
                        6'd2: rbyte = mt;
                        6'd3: rbyte = mo;
                        default: rbyte = 8'h3B;
                    endcase
                end
                else
                begin
                    rlen = 6'd4;
                    case (idx_reg)
                        6'd0: rbyte = "M";
                        6'd1: rbyte = "D";
                        6'd2: rbyte = mo;
                        default: rbyte = 8'h3B;
                    endcase
                end
            end
            default:
            begin
                rbyte = 8'h3B;
                rlen  = 6'd1;
            end
        endcase
    end

    assign ch0 = store_reg[0];
    assign ch1 = store_reg[1];

    // status to controller
    always_comb
    begin
        stat.is_semi    = (b == ccp_pkg::CHAR_SEMI);
        stat.len        = count_reg;
        stat.is_fa      = (ch0 == "F") && (ch1 == "A");
        stat.is_if      = (ch0 == "I") && (ch1 == "F");
        stat.is_id      = (ch0 == "I") && (ch1 == "D");
        stat.is_ps      = (ch0 == "P") && (ch1 == "S");
        stat.is_ai      = (ch0 == "A") && (ch1 == "I");
        stat.is_md      = (ch0 == "M") && (ch1 == "D");
        stat.is_rx      = (ch0 == "R") && (ch1 == "X");
        stat.is_tx      = (ch0 == "T") && (ch1 == "X");
        stat.conv_done  = (step_reg == 4'(ccp_pkg::FREQ_DIGITS - 1));
        stat.parse_done = (pidx_reg == 4'(ccp_pkg::STORE_DEPTH - 1));
        stat.reply_end  = (idx_reg == rlen - 6'd1);
    end

    // result payload: tuning result held for the whole tune request
    always_comb
    begin
        out_item.reply_channel = ch_reg;
        out_item.kind          = cmd.tune_show;
        out_item.tx_byte       = cmd.tune_show ? 8'd0 : rbyte;
        out_item.tuned_freq    = cmd.tune_show ? acc_reg[31:0] : 32'd0;
        out_item.last          = cmd.tune_show | stat.reply_end;
    end

endmodule

// ----- rtl/core/ccp_ctrl.sv -----
// ---------------------------------------------------------------------------
// ccp_ctrl
// Sequencer: takes bytes, decodes a finished line, streams the reply.
// ---------------------------------------------------------------------------
module ccp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ccp_pkg::ccp_stat_t stat,
    output ccp_pkg::ccp_cmd_t  cmd
);
    ccp_pkg::ccp_state_t state_reg, state_next;
    ccp_pkg::ccp_reply_t reply_reg, reply_next;
    logic two;
    logic [ccp_pkg::CNT_W-1:0] len_reg, len_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccp_pkg::ST_IDLE;
            reply_reg <= ccp_pkg::RPL_FA;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
            len_reg   <= len_next;
        end
    end

    assign two = (len_reg == ccp_pkg::CNT_W'(2));

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        len_next   = len_reg;
        cmd        = '0;
        cmd.reply  = reply_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ccp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.is_semi)
                    begin
                        cmd.latch_ch    = 1'b1;
                        cmd.clear_count = 1'b1;
                        len_next        = stat.len;
                        state_next      = ccp_pkg::ST_DECODE;
                    end
                    else
                    begin
                        cmd.store_byte = 1'b1;
                    end
                end
            end
            ccp_pkg::ST_DECODE:
            begin
                state_next    = ccp_pkg::ST_IDLE;
                cmd.idx_clear = 1'b1;
                if (len_reg >= ccp_pkg::CNT_W'(2))
                begin
                    if (stat.is_fa)
                    begin
                        if (two)
                        begin
                            reply_next     = ccp_pkg::RPL_FA;
                            cmd.conv_start = 1'b1;
                            state_next     = ccp_pkg::ST_CONV;
                        end
                        else if (len_reg >= ccp_pkg::CNT_W'(13))
                        begin
                            cmd.parse_start = 1'b1;
                            state_next      = ccp_pkg::ST_PARSE;
                        end
                    end
                    else if (stat.is_if)
                    begin
                        reply_next     = ccp_pkg::RPL_IF;
                        cmd.conv_start = 1'b1;
                        state_next     = ccp_pkg::ST_CONV;
                    end
                    else if (stat.is_id)
                    begin
                        reply_next = ccp_pkg::RPL_ID;
                        state_next = ccp_pkg::ST_SEND;
                    end
                    else if (stat.is_ps)
                    begin
                        if (two)
                        begin
                            reply_next = ccp_pkg::RPL_PS;
                            state_next = ccp_pkg::ST_SEND;
                        end
                    end
                    else if (stat.is_ai)
                    begin
                        if (two)
                        begin
                            reply_next = ccp_pkg::RPL_AI;
                            state_next = ccp_pkg::ST_SEND;
                        end
                    end
                    else if (stat.is_md)
                    begin
                        if (two)
                        begin
                            reply_next = ccp_pkg::RPL_MD;
                            state_next = ccp_pkg::ST_SEND;
                        end
                        else
                        begin
                            cmd.set_mode = 1'b1;
                        end
                    end
                    else if (stat.is_rx)
                    begin
                        cmd.clr_tx = 1'b1;
                    end
                    else if (stat.is_tx)
                    begin
                        cmd.set_tx = 1'b1;
                    end
                end
            end
            ccp_pkg::ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (stat.conv_done) state_next = ccp_pkg::ST_SEND;
            end
            ccp_pkg::ST_PARSE:
            begin
                cmd.parse_step = 1'b1;
                if (stat.parse_done) state_next = ccp_pkg::ST_TUNE;
            end
            ccp_pkg::ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.idx_inc = 1'b1;
                    if (stat.reply_end) state_next = ccp_pkg::ST_IDLE;
                end
            end
            ccp_pkg::ST_TUNE:
            begin
                out_valid     = 1'b1;
                cmd.tune_show = 1'b1;
                cmd.set_freq  = out_ready;
                if (out_ready) state_next = ccp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ccp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/cat_command_parser_top.sv -----
// ---------------------------------------------------------------------------
// cat_command_parser_top
// Transceiver command line parser: collects bytes, answers on semicolon.
// ---------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  in      | in  | in_valid / in_ready     | ccp_in_t  (channel, rx_byte)
//  out     | out | out_valid / out_ready   | ccp_out_t (reply fields)
//
// Ordinary bytes are taken one per cycle. A semicolon moves to a decode state,
// then FA/IF convert the frequency to decimal (one digit a cycle through
// the divide-by-ten unit) and FA set parses its digits, then one result
// per accepted output cycle. Input stalls until the last result is taken.
// Reset is asynchronous and restores the radio state.
// ---------------------------------------------------------------------------
module cat_command_parser_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ccp_pkg::ccp_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ccp_pkg::ccp_out_t out_data
);
    ccp_pkg::ccp_cmd_t  cmd;
    ccp_pkg::ccp_stat_t stat;

    ccp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath uses set_freq only when out_ready; tune value shown meanwhile
    ccp_pkg::ccp_cmd_t cmd_dp;
    always_comb
    begin
        cmd_dp = cmd;
    end

    ccp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd_dp),
        .stat     (stat),
        .out_item (out_data)
    );

endmodule
